// ===== hw/rtl/lsce_pkg.sv =====
// Shared types and constants for the laser stripe center extractor.
// No dependencies; every other file of the block imports this package.
package lsce_pkg;

  localparam int MAX_COLUMNS = 4096;
  localparam int MAX_ROWS    = 4096;
  localparam int COL_W       = 12;
  localparam int CNT_W       = 13;
  localparam int ROW_W       = 12;
  localparam int GRAD_W      = 9;
  localparam int CENTRE_W    = 20;
  localparam int CENTRE_MAX  = 1048320;

  localparam logic [1:0] REG_GRAD_THRESHOLD = 2'd0;
  localparam logic [1:0] REG_WIDTH_MIN      = 2'd1;
  localparam logic [1:0] REG_WIDTH_MAX      = 2'd2;

  typedef struct packed {
    logic        [8:0]  thr;
    logic signed [12:0] wmin;
    logic signed [12:0] wmax;
  } cfg_t;

  typedef struct packed {
    logic signed [GRAD_W-1:0] pk0;
    logic signed [GRAD_W-1:0] pk1;
    logic signed [GRAD_W-1:0] pk2;
    logic signed [GRAD_W-1:0] tr0;
    logic signed [GRAD_W-1:0] tr1;
    logic signed [GRAD_W-1:0] tr2;
    logic signed [GRAD_W-1:0] prev;
    logic        [COL_W-1:0]  pk_col;
    logic        [COL_W-1:0]  tr_col;
    logic                     pk_pend;
    logic                     tr_pend;
  } track_t;

  typedef struct packed {
    logic signed [GRAD_W-1:0] pk0;
    logic signed [GRAD_W-1:0] pk1;
    logic signed [GRAD_W-1:0] pk2;
    logic signed [GRAD_W-1:0] tr0;
    logic signed [GRAD_W-1:0] tr1;
    logic signed [GRAD_W-1:0] tr2;
    logic        [COL_W-1:0]  m;
    logic        [COL_W-1:0]  nn;
    logic        [CNT_W-1:0]  n;
    logic        [ROW_W-1:0]  row;
    logic                     last;
  } job_t;

endpackage

// ===== hw/rtl/lsce_front.sv =====
// Pixel front end: gradient, extremum tracking and row bookkeeping.
// Depends on lsce_pkg; emits one job per row end into the job queue.
module lsce_front import lsce_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              accept,
  input  logic [7:0]        pixel,
  input  logic              row_end,
  input  logic              frame_end,
  output logic              job_push,
  output job_t              job
);

  logic [7:0]       pd0_r, pd1_r;
  logic [CNT_W-1:0] col_cnt_r;
  logic [ROW_W-1:0] row_cnt_r;
  track_t           trk_r;

  logic                     in_room;
  logic signed [GRAD_W-1:0] grad;
  logic [CNT_W-1:0]         n_cols;
  logic [CNT_W-1:0]         k_m1;
  logic [CNT_W-1:0]         n_m1;
  track_t                   trk1, trk2;

  function automatic track_t take_grad(track_t s, logic signed [GRAD_W-1:0] g,
                                       logic [COL_W-1:0] c);
    track_t r;
    r = s;
    if (r.pk_pend) begin
      r.pk2 = g;
      r.pk_pend = 1'b0;
    end
    if (r.tr_pend) begin
      r.tr2 = g;
      r.tr_pend = 1'b0;
    end
    if (c == '0 || g >= r.pk1) begin
      r.pk0 = s.prev;
      r.pk1 = g;
      r.pk2 = '0;
      r.pk_col = c;
      r.pk_pend = 1'b1;
    end
    if (c == '0 || g < r.tr1) begin
      r.tr0 = s.prev;
      r.tr1 = g;
      r.tr2 = '0;
      r.tr_col = c;
      r.tr_pend = 1'b1;
    end
    r.prev = g;
    return r;
  endfunction

  always_comb begin
    in_room = col_cnt_r < CNT_W'(MAX_COLUMNS);
    k_m1 = col_cnt_r - CNT_W'(1);
    if (col_cnt_r == CNT_W'(1)) begin
      grad = '0;
    end else begin
      grad = $signed({1'b0, pixel}) - $signed({1'b0, pd1_r});
    end
    trk1 = trk_r;
    if (in_room && col_cnt_r != '0) begin
      trk1 = take_grad(trk_r, grad, k_m1[COL_W-1:0]);
    end
    n_cols = in_room ? col_cnt_r + CNT_W'(1) : col_cnt_r;
    n_m1 = n_cols - CNT_W'(1);
    trk2 = take_grad(trk1, '0, n_m1[COL_W-1:0]);

    job_push = accept && row_end;
    job.pk0  = trk2.pk0;
    job.pk1  = trk2.pk1;
    job.pk2  = trk2.pk2;
    job.tr0  = trk2.tr0;
    job.tr1  = trk2.tr1;
    job.tr2  = trk2.tr2;
    job.m    = trk2.pk_col;
    job.nn   = trk2.tr_col;
    job.n    = n_cols;
    job.row  = row_cnt_r;
    job.last = frame_end;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pd0_r <= '0;
      pd1_r <= '0;
      col_cnt_r <= '0;
      row_cnt_r <= '0;
      trk_r <= '0;
    end else if (accept) begin
      if (row_end) begin
        pd0_r <= '0;
        pd1_r <= '0;
        col_cnt_r <= '0;
        trk_r <= '0;
        if (frame_end) begin
          row_cnt_r <= '0;
        end else if (row_cnt_r < ROW_W'(MAX_ROWS - 1)) begin
          row_cnt_r <= row_cnt_r + ROW_W'(1);
        end
      end else begin
        trk_r <= trk1;
        if (in_room) begin
          pd1_r <= pd0_r;
          pd0_r <= pixel;
          col_cnt_r <= col_cnt_r + CNT_W'(1);
        end
      end
    end
  end

endmodule

// ===== hw/rtl/lsce_job_fifo.sv =====
// Two-entry queue of row jobs between the pixel front end and the solver.
// Depends on lsce_pkg for the job type.
module lsce_job_fifo import lsce_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_job,
  input  logic pop,
  output job_t pop_job,
  output logic full,
  output logic empty
);

  job_t       slot_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] count_r;
  logic       do_push, do_pop;

  assign full    = count_r == 2'd2;
  assign empty   = count_r == 2'd0;
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign pop_job = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (do_pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 2'd1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 2'd1;
      end
    end
  end

endmodule

// ===== hw/rtl/lsce_back.sv =====
// Row solver: stripe filters, parabola refinement and the center division.
// Depends on lsce_pkg; takes jobs from the queue and holds the result register.
module lsce_back import lsce_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  cfg_t                cfg,
  input  logic                job_empty,
  input  job_t                job,
  output logic                job_pop,
  output logic                out_empty,
  input  logic                out_pop,
  output logic [ROW_W-1:0]    out_row_number,
  output logic                out_found,
  output logic [CENTRE_W-1:0] out_centre_q8,
  output logic                out_last
);

  typedef enum logic [3:0] {
    S_IDLE, S_PREP, S_M1, S_M2, S_M3, S_NORM, S_M4, S_NUM, S_OVF, S_DIV, S_DONE
  } state_t;

  state_t state_r;
  job_t   job_r;
  logic   pass_r;
  logic signed [10:0] a1_r, a2_r;
  logic signed [9:0]  b1_r, b2_r;
  logic [CNT_W-1:0]   sum_r;
  logic signed [21:0] den_r;
  logic signed [20:0] s1_r;
  logic signed [21:0] s_r;
  logic [33:0]        prod_r;
  logic signed [43:0] num_r;
  logic [42:0]        rem_r, dsh_r;
  logic [20:0]        q_r;
  logic [4:0]         cnt_r;
  logic               out_valid_r;

  logic signed [10:0] thr_s, pk0_e, pk1_e, pk2_e, tr0_e, tr1_e, tr2_e;
  logic signed [12:0] wid;
  logic [CNT_W-1:0]   n_m1;
  logic               pass_nxt;
  logic signed [21:0] m1_prod;
  logic signed [20:0] m2_prod;
  logic signed [21:0] m3_prod;
  logic [21:0]        dvs;
  logic [CENTRE_W-1:0] centre_sat;
  logic               out_load;

  always_comb begin
    thr_s = $signed({2'b00, cfg.thr});
    pk0_e = 11'(job_r.pk0);
    pk1_e = 11'(job_r.pk1);
    pk2_e = 11'(job_r.pk2);
    tr0_e = 11'(job_r.tr0);
    tr1_e = 11'(job_r.tr1);
    tr2_e = 11'(job_r.tr2);
    wid = $signed({1'b0, job_r.nn}) - $signed({1'b0, job_r.m});
    n_m1 = job_r.n - CNT_W'(1);
    pass_nxt = (pk1_e >= thr_s) && (tr1_e <= -thr_s)
               && (wid >= cfg.wmin) && (wid <= cfg.wmax)
               && (job_r.m != '0) && ({1'b0, job_r.m} < n_m1)
               && (job_r.nn != '0) && ({1'b0, job_r.nn} < n_m1);
    m1_prod = a1_r * a2_r;
    m2_prod = b1_r * a2_r;
    m3_prod = b2_r * a1_r;
    dvs = {den_r[20:0], 1'b0};
    centre_sat = (q_r > 21'(CENTRE_MAX)) ? CENTRE_W'(CENTRE_MAX) : q_r[CENTRE_W-1:0];
  end

  assign job_pop   = (state_r == S_IDLE) && !job_empty;
  assign out_empty = !out_valid_r;
  assign out_load  = (state_r == S_DONE) && (!out_valid_r || out_pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_pop) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (!job_empty) begin
            job_r <= job;
            state_r <= S_PREP;
          end
        end
        S_PREP: begin
          pass_r <= pass_nxt;
          a1_r <= pk0_e + pk2_e - (pk1_e <<< 1);
          a2_r <= tr0_e + tr2_e - (tr1_e <<< 1);
          b1_r <= 10'(pk2_e - pk0_e);
          b2_r <= 10'(tr2_e - tr0_e);
          sum_r <= {1'b0, job_r.m} + {1'b0, job_r.nn};
          state_r <= pass_nxt ? S_M1 : S_DONE;
        end
        S_M1: begin
          den_r <= -m1_prod;
          state_r <= S_M2;
        end
        S_M2: begin
          s1_r <= m2_prod;
          state_r <= S_M3;
        end
        S_M3: begin
          s_r <= 22'(s1_r) + m3_prod;
          state_r <= S_NORM;
        end
        S_NORM: begin
          if (den_r == '0) begin
            pass_r <= 1'b0;
            state_r <= S_DONE;
          end else begin
            if (den_r < 0) begin
              den_r <= -den_r;
              s_r <= -s_r;
            end
            state_r <= S_M4;
          end
        end
        S_M4: begin
          prod_r <= {21'b0, sum_r} * {13'b0, den_r[20:0]};
          state_r <= S_NUM;
        end
        S_NUM: begin
          num_r <= $signed({2'b00, prod_r, 8'b0})
                   + $signed({{15{s_r[21]}}, s_r, 7'b0})
                   + $signed({23'b0, den_r[20:0]});
          state_r <= S_OVF;
        end
        S_OVF: begin
          if (num_r[43]) begin
            q_r <= '0;
            state_r <= S_DONE;
          end else if (num_r[42:0] >= {dvs, 21'b0}) begin
            q_r <= '1;
            state_r <= S_DONE;
          end else begin
            rem_r <= num_r[42:0];
            dsh_r <= {1'b0, dvs, 20'b0};
            q_r <= '0;
            cnt_r <= 5'd20;
            state_r <= S_DIV;
          end
        end
        S_DIV: begin
          if (rem_r >= dsh_r) begin
            rem_r <= rem_r - dsh_r;
            q_r <= {q_r[19:0], 1'b1};
          end else begin
            q_r <= {q_r[19:0], 1'b0};
          end
          dsh_r <= dsh_r >> 1;
          cnt_r <= cnt_r - 5'd1;
          if (cnt_r == '0) begin
            state_r <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_load) begin
            out_row_number <= job_r.row;
            out_found <= pass_r;
            out_centre_q8 <= pass_r ? centre_sat : '0;
            out_last <= job_r.last;
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== hw/rtl/laser_stripe_center_extract.sv =====
// Top level of the laser stripe center extractor with its configuration registers.
// Depends on lsce_pkg, lsce_front, lsce_job_fifo and lsce_back.
//
// Pixels enter one per clock in row order while in_full is low; the front end forms the
// gradient and tracks the rising and falling stripe edges as they stream by. Each row end
// hands a job to a two-row queue, and the solver turns it into one result, finishing one
// row before it takes the next; a 21-step restoring divider dominates the solve time when
// the edges pass the filters, and rows that fail them skip the arithmetic. Input stalls
// (in_full) only while the queue already holds two rows, so rows longer than the solve
// time run at the full pixel rate. Configuration writes are accepted every cycle.
module laser_stripe_center_extract import lsce_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_push,
  output logic                in_full,
  input  logic [7:0]          in_pixel,
  input  logic                in_row_end,
  input  logic                in_frame_end,
  output logic                out_empty,
  input  logic                out_pop,
  output logic [ROW_W-1:0]    out_row_number,
  output logic                out_found,
  output logic [CENTRE_W-1:0] out_centre_q8,
  output logic                out_last,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [12:0]         cfg_data
);

  cfg_t cfg_r;
  logic accept;
  logic job_push, job_pop, job_full, job_empty;
  job_t push_job, pop_job;

  assign cfg_ready = 1'b1;
  assign in_full   = job_full;
  assign accept    = in_push && !job_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.thr <= 9'd35;
      cfg_r.wmin <= 13'sd1;
      cfg_r.wmax <= 13'sd20;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_GRAD_THRESHOLD: cfg_r.thr <= cfg_data[8:0];
        REG_WIDTH_MIN:      cfg_r.wmin <= $signed(cfg_data);
        REG_WIDTH_MAX:      cfg_r.wmax <= $signed(cfg_data);
        default: begin
        end
      endcase
    end
  end

  lsce_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .pixel     (in_pixel),
    .row_end   (in_row_end),
    .frame_end (in_frame_end),
    .job_push  (job_push),
    .job       (push_job)
  );

  lsce_job_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (job_push),
    .push_job (push_job),
    .pop      (job_pop),
    .pop_job  (pop_job),
    .full     (job_full),
    .empty    (job_empty)
  );

  lsce_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg_r),
    .job_empty      (job_empty),
    .job            (pop_job),
    .job_pop        (job_pop),
    .out_empty      (out_empty),
    .out_pop        (out_pop),
    .out_row_number (out_row_number),
    .out_found      (out_found),
    .out_centre_q8  (out_centre_q8),
    .out_last       (out_last)
  );

endmodule

// ===== sim/tb_top.sv =====
// Self-checking testbench for laser_stripe_center_extract: streams pixel rows, predicts each
// row's stripe center and compares every popped result with the oldest prediction.
// Depends on lsce_pkg and the laser_stripe_center_extract RTL.
module tb_top;
  import lsce_pkg::*;

  localparam logic [1:0] REG_SPARE = 2'd3;
  localparam int HOLD_CYCLES = 600;

  typedef struct packed {
    logic [7:0] pixel;
    logic       row_end;
    logic       frame_end;
  } pixel_req_t;

  typedef struct packed {
    logic [ROW_W-1:0]    row;
    logic                found;
    logic [CENTRE_W-1:0] centre;
    logic                last;
  } centre_rec_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_push = 1'b0;
  logic in_full;
  logic [7:0] in_pixel = '0;
  logic in_row_end = 1'b0;
  logic in_frame_end = 1'b0;
  logic out_empty;
  logic out_pop = 1'b0;
  logic [ROW_W-1:0] out_row_number;
  logic out_found;
  logic [CENTRE_W-1:0] out_centre_q8;
  logic out_last;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = REG_GRAD_THRESHOLD;
  logic [12:0] cfg_data = '0;

  pixel_req_t pixel_reqs[$];
  centre_rec_t centres_due[$];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  bit pressure_on = 1'b0;
  bit hold_used = 1'b0;
  int hold_left = 0;
  int err_count = 0;
  int pixels_taken = 0;
  int rows_checked = 0;
  int rows_found = 0;
  int cfg_writes = 0;

  logic [7:0] px_hist [2];
  int col_count;
  int row_index;
  int pk_g [3];
  int tr_g [3];
  int pk_col;
  int tr_col;
  bit pk_wait;
  bit tr_wait;
  int last_grad;
  int thr_cfg = 35;
  int wmin_cfg = 1;
  int wmax_cfg = 20;

  laser_stripe_center_extract dut (
    .clk(clk), .rst_n(rst_n),
    .in_push(in_push), .in_full(in_full), .in_pixel(in_pixel),
    .in_row_end(in_row_end), .in_frame_end(in_frame_end),
    .out_empty(out_empty), .out_pop(out_pop), .out_row_number(out_row_number),
    .out_found(out_found), .out_centre_q8(out_centre_q8), .out_last(out_last),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic void clear_row_track();
    for (int i = 0; i < 3; i++) begin
      pk_g[i] = 0;
      tr_g[i] = 0;
    end
    px_hist[0] = '0;
    px_hist[1] = '0;
    col_count = 0;
    pk_col = 0;
    tr_col = 0;
    pk_wait = 1'b0;
    tr_wait = 1'b0;
    last_grad = 0;
  endfunction

  function automatic void take_edge(int g, int c);
    if (pk_wait) begin
      pk_g[2] = g;
      pk_wait = 1'b0;
    end
    if (tr_wait) begin
      tr_g[2] = g;
      tr_wait = 1'b0;
    end
    if (c == 0 || g >= pk_g[1]) begin
      pk_g[0] = last_grad;
      pk_g[1] = g;
      pk_g[2] = 0;
      pk_col = c;
      pk_wait = 1'b1;
    end
    if (c == 0 || g < tr_g[1]) begin
      tr_g[0] = last_grad;
      tr_g[1] = g;
      tr_g[2] = 0;
      tr_col = c;
      tr_wait = 1'b1;
    end
    last_grad = g;
  endfunction

  function automatic void trace_stripe(logic [7:0] px, logic re, logic fe);
    int g, n, wid;
    longint m, nn, a1, b1, a2, b2, den, s, t, num, v;
    bit ok;
    centre_rec_t rec;
    pixels_taken++;
    if (col_count < MAX_COLUMNS) begin
      if (col_count >= 1) begin
        g = (col_count == 1) ? 0 : int'(px) - int'(px_hist[1]);
        take_edge(g, col_count - 1);
      end
      px_hist[1] = px_hist[0];
      px_hist[0] = px;
      col_count++;
    end
    if (!re) return;
    n = col_count;
    take_edge(0, n - 1);
    m = pk_col;
    nn = tr_col;
    wid = int'(nn - m);
    ok = !(pk_g[1] < thr_cfg || tr_g[1] > -thr_cfg);
    ok = ok && wid >= wmin_cfg && wid <= wmax_cfg;
    ok = ok && m > 0 && m < n - 1 && nn > 0 && nn < n - 1;
    v = 0;
    if (ok) begin
      a1 = pk_g[0] + pk_g[2] - 2 * pk_g[1];
      b1 = pk_g[2] - pk_g[0];
      a2 = tr_g[0] + tr_g[2] - 2 * tr_g[1];
      b2 = tr_g[2] - tr_g[0];
      den = -a1 * a2;
      s = b1 * a2 + b2 * a1;
      if (den < 0) begin
        den = -den;
        s = -s;
      end
      if (den == 0) begin
        ok = 1'b0;
      end else begin
        t = 128 * (m + nn) * den + 64 * s;
        num = 2 * t + den;
        v = num / (2 * den);
        if (num % (2 * den) != 0 && num < 0) v--;
        if (v < 0) v = 0;
        if (v > CENTRE_MAX) v = CENTRE_MAX;
      end
    end
    rec.row = row_index[ROW_W-1:0];
    rec.found = ok;
    rec.centre = ok ? v[CENTRE_W-1:0] : '0;
    rec.last = fe;
    centres_due.push_back(rec);
    if (ok) rows_found++;
    if (fe) row_index = 0;
    else if (row_index < MAX_ROWS - 1) row_index++;
    clear_row_track();
  endfunction

  function automatic void push_px(int px, bit re, bit fe);
    pixel_req_t req;
    req.pixel = px[7:0];
    req.row_end = re;
    req.frame_end = fe;
    pixel_reqs.push_back(req);
  endfunction

  function automatic void queue_row(int ncols, bit close_frame);
    int kind, base, peak, ctr, hw, jitter, val, d, ramp;
    bit re;
    kind = $urandom_range(99);
    base = $urandom_range(50);
    peak = $urandom_range(255, 40);
    ctr = $urandom_range(ncols - 1);
    hw = $urandom_range(12, 1);
    jitter = $urandom_range(8);
    for (int c = 0; c < ncols; c++) begin
      if (kind < 15) begin
        val = $urandom_range(255);
      end else begin
        val = base + $urandom_range(jitter);
        d = (c > ctr) ? c - ctr : ctr - c;
        ramp = peak - (peak - base) * d / (hw + 1);
        if (kind < 85 && d <= hw && ramp > val) val = ramp;
      end
      if (val > 255) val = 255;
      re = (c == ncols - 1);
      push_px(val, re, re ? close_frame : ($urandom_range(19) == 0));
    end
  endfunction

  function automatic int pick_cols();
    int r;
    r = $urandom_range(99);
    if (r < 5) return $urandom_range(2, 1);
    if (r < 90) return $urandom_range(24, 3);
    return $urandom_range(80, 25);
  endfunction

  task automatic wait_drained();
    do @(negedge clk);
    while (pixel_reqs.size() != 0 || in_push || centres_due.size() != 0);
    repeat (48) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [12:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk);
    while (!cfg_ready);
    cfg_valid <= 1'b0;
    cfg_writes++;
    case (idx)
      REG_GRAD_THRESHOLD: thr_cfg = int'(data[8:0]);
      REG_WIDTH_MIN:      wmin_cfg = int'($signed(data));
      REG_WIDTH_MAX:      wmax_cfg = int'($signed(data));
      default: ;
    endcase
  endtask

  task automatic run_random(int send_pct, int recv_pct, bit hold, int pix_budget,
                            int row_budget, int short_max);
    int pix, rows, n;
    @(negedge clk);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    pressure_on = hold;
    pix = 0;
    rows = 0;
    while (pix < pix_budget || rows < row_budget) begin
      n = (short_max > 0) ? $urandom_range(short_max, 3) : pick_cols();
      queue_row(n, $urandom_range(9) == 0);
      pix += n;
      rows++;
    end
    wait_drained();
  endtask

  always @(posedge clk) begin
    pixel_req_t nxt;
    if (!rst_n) begin
      in_push <= 1'b0;
    end else begin
      if (in_push && !in_full) trace_stripe(in_pixel, in_row_end, in_frame_end);
      if (!in_push || !in_full) begin
        if (pixel_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt = pixel_reqs[0];
          pixel_reqs.delete(0);
          in_push <= 1'b1;
          in_pixel <= nxt.pixel;
          in_row_end <= nxt.row_end;
          in_frame_end <= nxt.frame_end;
        end else begin
          in_push <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (pressure_on && !hold_used) begin
      hold_left <= HOLD_CYCLES;
      hold_used <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk) begin
    centre_rec_t want;
    if (!rst_n) begin
      out_pop <= 1'b0;
    end else begin
      if (out_pop && !out_empty) begin
        rows_checked++;
        if (centres_due.size() == 0) begin
          $error("unexpected result for row %0d", out_row_number);
          err_count++;
        end else begin
          want = centres_due[0];
          centres_due.delete(0);
          if (out_row_number !== want.row) begin
            $error("row_number: expected %0d, got %0d", want.row, out_row_number);
            err_count++;
          end
          if (out_found !== want.found) begin
            $error("found: expected %0d, got %0d", want.found, out_found);
            err_count++;
          end
          if (out_centre_q8 !== want.centre) begin
            $error("centre_q8: expected %0d, got %0d", want.centre, out_centre_q8);
            err_count++;
          end
          if (out_last !== want.last) begin
            $error("last: expected %0d, got %0d", want.last, out_last);
            err_count++;
          end
        end
      end
      out_pop <= (hold_left == 0) && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  initial begin
    #4_000_000;
    $display("laser_stripe_center_extract test failed");
    $finish;
  end

  initial begin
    row_index = 0;
    clear_row_track();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    @(negedge clk);
    push_px(255, 1, 0);
    push_px(0, 0, 0); push_px(255, 1, 0);
    push_px(0, 0, 0); push_px(0, 0, 0); push_px(0, 0, 0);
    push_px(255, 0, 0); push_px(255, 0, 0); push_px(255, 0, 0);
    push_px(0, 0, 0); push_px(0, 0, 0); push_px(0, 1, 0);
    push_px(255, 0, 0); push_px(255, 0, 0); push_px(0, 0, 0); push_px(0, 1, 0);
    push_px(10, 0, 0); push_px(10, 0, 1); push_px(200, 0, 0);
    push_px(10, 0, 0); push_px(10, 1, 1);
    push_px(0, 0, 0); push_px(255, 0, 0); push_px(0, 1, 0);
    wait_drained();

    write_reg(REG_GRAD_THRESHOLD, 13'd20);
    write_reg(REG_WIDTH_MIN, 13'd1);
    write_reg(REG_WIDTH_MAX, 13'd30);
    run_random(33, 77, 1'b0, 100, 6, 0);

    write_reg(REG_GRAD_THRESHOLD, 13'd0);
    write_reg(REG_WIDTH_MIN, 13'h1000);
    write_reg(REG_WIDTH_MAX, 13'h0FFF);
    write_reg(REG_SPARE, 13'h1ABC);
    run_random(77, 33, 1'b0, 100, 6, 0);

    write_reg(REG_GRAD_THRESHOLD, 13'd8);
    write_reg(REG_WIDTH_MAX, 13'd6);
    write_reg(REG_WIDTH_MIN, 13'd1);
    run_random(0, 0, 1'b1, 80, 14, 8);

    write_reg(REG_GRAD_THRESHOLD, 13'h1FFF);
    write_reg(REG_WIDTH_MIN, 13'h0FFF);
    write_reg(REG_WIDTH_MAX, 13'h1000);
    run_random(0, 0, 1'b0, 40, 3, 0);

    $display("Covered %0d pixels in %0d checked rows, %0d with a center found, %0d writes.",
             pixels_taken, rows_checked, rows_found, cfg_writes);
    $display("Runs included one-column rows, border edges, frame ends and a long stall.");
    if (err_count == 0) begin
      $display("laser_stripe_center_extract test passed");
    end else begin
      $display("laser_stripe_center_extract test failed");
    end
    $finish;
  end

endmodule
